[design/best_fit_free_area_table_defines.svh]
// assertion macros for the free area table
`ifndef BEST_FIT_FREE_AREA_TABLE_DEFINES_SVH
`define BEST_FIT_FREE_AREA_TABLE_DEFINES_SVH

// clocked property, off during reset
`define BFA_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold at a clock edge
`define BFA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[design/bfa_pkg.sv]
// ----------------------------------------------------------------------------
// bfa_pkg
// shared constants and command codes of the best fit free area table
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

  localparam int unsigned SlotsDef    = 256;
  localparam int unsigned SizeBitsDef = 32;
  localparam int unsigned AddrBitsDef = 32;
  localparam int unsigned SumBits     = 40;

  typedef enum logic [3:0] {
    CMD_ADD         = 4'd0,
    CMD_REMOVE      = 4'd1,
    CMD_JOIN        = 4'd2,
    CMD_ATTACH      = 4'd3,
    CMD_EXPAND      = 4'd4,
    CMD_SHRINK_UP   = 4'd5,
    CMD_SHRINK_DOWN = 4'd6,
    CMD_FIND        = 4'd7,
    CMD_READ        = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

`default_nettype wire

[design/best_fit_free_area_table.sv]
// ----------------------------------------------------------------------------
// best_fit_free_area_table
// table of free memory areas with add, remove, merge, resize and best fit find
// ----------------------------------------------------------------------------
// A command transfers in when start is high and busy is low. Exactly one
// result per command comes back on slot_o, size_o, addr_out_o, status_o and
// free_total_o, valid for the single cycle in which done_o is high; the
// receiver takes it in that cycle and cannot stall.
// All slot entries sit in one memory with one read and one write port and
// registered read data; the sequencer reads, modifies and writes back.
// Steps per command, accept to strobe:
//   read, attach, expand, shrink : read slot, modify, write back (read: none)
//   remove                        : read, clear; top slot then trims empty slots
//   join                          : read both, merge, clear; top slot then trims
//   add with no gaps, invalid slot, early find miss, unknown command : no scan
//   add with gaps, find           : scan up to top count (one slot per cycle)
// busy stays high from accept up to and including the strobe cycle.
// After reset a clearing pass writes every slot to empty, one per cycle,
// with busy high; no command is taken during that pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "best_fit_free_area_table_defines.svh"

module best_fit_free_area_table #(
  parameter int unsigned SLOTS     = bfa_pkg::SlotsDef,
  parameter int unsigned SIZE_BITS = bfa_pkg::SizeBitsDef,
  parameter int unsigned ADDR_BITS = bfa_pkg::AddrBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  cmd_i,
  input  wire logic [7:0]  slot_a_i,
  input  wire logic [7:0]  slot_b_i,
  input  wire logic [31:0] addr_i,
  input  wire logic [31:0] amount_i,
  output logic             done_o,
  output logic [7:0]       slot_o,
  output logic [31:0]      size_o,
  output logic [31:0]      addr_out_o,
  output logic [1:0]       status_o,
  output logic [39:0]      free_total_o
);

  import bfa_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned TW = IW + 1;
  localparam int unsigned CW = (TW > 8) ? TW : 8;
  localparam int unsigned SW = SIZE_BITS;
  localparam int unsigned AW = ADDR_BITS;
  localparam int unsigned EW = SW + AW;
  localparam int unsigned HW = (SW > SumBits) ? SW : SumBits;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_ADD, S_MOD, S_JB, S_JMOD, S_JCLR,
    S_TRIM_RD, S_TRIM_CHK, S_RESP
  } state_e;

  state_e            state_q, state_d;
  logic [3:0]        cmd_q, cmd_d;
  logic [7:0]        a_q, a_d, b_q, b_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [SW-1:0]     amt_q, amt_d;
  logic [TW-1:0]     top_q, top_d, gap_q, gap_d, idx_q, idx_d;
  logic [SumBits-1:0] fsum_q, fsum_d;
  logic [SW-1:0]     hint_q, hint_d, large_q, large_d, bsize_q, bsize_d;
  logic [IW-1:0]     chk_q, chk_d, best_q, best_d;
  logic              pend_q, pend_d, have_q, have_d;
  logic [AW-1:0]     baddr_q, baddr_d;
  logic [EW-1:0]     da_q, da_d;
  logic [7:0]        res_slot_q, res_slot_d;
  logic [31:0]       res_size_q, res_size_d, res_addr_q, res_addr_d;
  logic [1:0]        res_st_q, res_st_d;

  logic              rd_en, wr_en;
  logic [IW-1:0]     rd_idx, wr_idx;
  logic [EW-1:0]     rdata, wr_data;
  logic [SW-1:0]     rd_s;
  logic [AW-1:0]     rd_a;

  assign rd_s = rdata[EW-1:AW];
  assign rd_a = rdata[AW-1:0];

  bfa_mem #(
    .DEPTH (SLOTS),
    .WIDTH (EW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rdata),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data)
  );

  always_comb begin
    logic [SW-1:0] amt_in, ns, sa;
    logic [AW-1:0] no;
    logic          issue, hit, a_in_ok, b_in_ok;
    logic [IW-1:0] lo, hi;

    state_d    = state_q;
    cmd_d      = cmd_q;
    a_d        = a_q;
    b_d        = b_q;
    addr_d     = addr_q;
    amt_d      = amt_q;
    top_d      = top_q;
    gap_d      = gap_q;
    idx_d      = idx_q;
    fsum_d     = fsum_q;
    hint_d     = hint_q;
    large_d    = large_q;
    bsize_d    = bsize_q;
    chk_d      = chk_q;
    best_d     = best_q;
    pend_d     = pend_q;
    have_d     = have_q;
    baddr_d    = baddr_q;
    da_d       = da_q;
    res_slot_d = res_slot_q;
    res_size_d = res_size_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    rd_en      = 1'b0;
    rd_idx     = '0;
    wr_en      = 1'b0;
    wr_idx     = '0;
    wr_data    = '0;
    amt_in     = SW'(amount_i);
    ns         = '0;
    no         = '0;
    issue      = 1'b0;
    hit        = 1'b0;
    a_in_ok    = CW'(slot_a_i) < CW'(top_q);
    b_in_ok    = CW'(slot_b_i) < CW'(top_q);
    lo         = '0;
    hi         = '0;
    sa         = da_q[EW-1:AW];

    unique case (state_q)
      S_CLEAR: begin
        wr_en  = 1'b1;
        wr_idx = idx_q[IW-1:0];
        if (idx_q == TW'(SLOTS - 1)) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          cmd_d      = cmd_i;
          a_d        = slot_a_i;
          b_d        = slot_b_i;
          addr_d     = AW'(addr_i);
          amt_d      = amt_in;
          res_slot_d = '0;
          res_size_d = '0;
          res_addr_d = '0;
          res_st_d   = ST_OK;
          idx_d      = '0;
          pend_d     = 1'b0;
          have_d     = 1'b0;
          large_d    = '0;
          if (cmd_i == CMD_ADD) begin
            state_d = (gap_q != '0) ? S_SCAN : S_ADD;
          end else if (cmd_i == CMD_FIND) begin
            if (HW'(amt_in) > HW'(hint_q) || HW'(amt_in) > HW'(fsum_q)) begin
              res_st_d = ST_NOFIT;
              state_d  = S_RESP;
            end else begin
              state_d = S_SCAN;
            end
          end else if (cmd_i > CMD_READ) begin
            state_d = S_RESP;
          end else if (!a_in_ok || (cmd_i == CMD_JOIN && !b_in_ok)) begin
            res_slot_d = slot_a_i;
            res_st_d   = ST_NOFIT;
            state_d    = S_RESP;
          end else begin
            rd_en   = 1'b1;
            rd_idx  = IW'(slot_a_i);
            state_d = (cmd_i == CMD_JOIN && slot_a_i != slot_b_i) ? S_JB : S_MOD;
          end
        end
      end

      S_SCAN: begin
        // one slot issued per cycle, checked when its read data returns
        issue = idx_q < top_q;
        if (issue) begin
          rd_en  = 1'b1;
          rd_idx = idx_q[IW-1:0];
          idx_d  = idx_q + 1'b1;
          chk_d  = idx_q[IW-1:0];
        end
        pend_d = issue;
        if (pend_q) begin
          if (cmd_q == CMD_ADD) begin
            hit = rd_s == '0;
          end else if (rd_s != '0) begin
            if (rd_s == amt_q) begin
              hit = 1'b1;
            end else begin
              if (rd_s > large_q) begin
                large_d = rd_s;
              end
              if (rd_s > amt_q && (!have_q || rd_s <= bsize_q)) begin
                have_d  = 1'b1;
                best_d  = chk_q;
                bsize_d = rd_s;
                baddr_d = rd_a;
              end
            end
          end
        end
        if (hit || (!pend_q && !issue)) begin
          if (cmd_q == CMD_ADD) begin
            have_d  = hit;
            best_d  = chk_q;
            state_d = S_ADD;
          end else begin
            state_d = S_RESP;
            if (hit) begin
              res_slot_d = 8'(chk_q);
              res_size_d = 32'(rd_s);
              res_addr_d = 32'(rd_a);
            end else begin
              hint_d = large_q;
              if (have_q) begin
                res_slot_d = 8'(best_q);
                res_size_d = 32'(bsize_q);
                res_addr_d = 32'(baddr_q);
              end else begin
                res_st_d = ST_NOFIT;
              end
            end
          end
        end
      end

      S_ADD: begin
        state_d = S_RESP;
        if (have_q) begin
          gap_d  = gap_q - 1'b1;
          wr_idx = best_q;
        end else begin
          gap_d  = '0;
          wr_idx = top_q[IW-1:0];
        end
        if (!have_q && top_q >= TW'(SLOTS)) begin
          res_st_d = ST_FULL;
        end else begin
          if (!have_q) begin
            top_d = top_q + 1'b1;
          end
          wr_en   = 1'b1;
          wr_data = {amt_q, addr_q};
          if (amt_q > hint_q) begin
            hint_d = amt_q;
          end
          fsum_d     = fsum_q + SumBits'(amt_q);
          res_slot_d = 8'(wr_idx);
          res_size_d = 32'(amt_q);
          res_addr_d = 32'(addr_q);
        end
      end

      S_MOD: begin
        state_d    = S_RESP;
        wr_idx     = IW'(a_q);
        res_slot_d = a_q;
        res_size_d = 32'(rd_s);
        res_addr_d = 32'(rd_a);
        case (cmd_q) inside
          CMD_REMOVE: begin
            fsum_d = fsum_q - SumBits'(rd_s);
            wr_en  = 1'b1;
            if (CW'(a_q) == CW'(top_q - 1'b1)) begin
              top_d   = top_q - 1'b1;
              state_d = S_TRIM_RD;
            end else if (gap_q < TW'(SLOTS)) begin
              gap_d = gap_q + 1'b1;
            end
          end
          CMD_ATTACH, CMD_EXPAND, CMD_SHRINK_UP, CMD_SHRINK_DOWN: begin
            wr_en = 1'b1;
            if (cmd_q == CMD_ATTACH || cmd_q == CMD_EXPAND) begin
              ns     = rd_s + amt_q;
              fsum_d = fsum_q + SumBits'(amt_q);
            end else begin
              ns     = rd_s - amt_q;
              fsum_d = fsum_q - SumBits'(amt_q);
            end
            if (cmd_q == CMD_EXPAND) begin
              no = rd_a - AW'(amt_q);
            end else if (cmd_q == CMD_SHRINK_UP) begin
              no = rd_a + AW'(amt_q);
            end else begin
              no = rd_a;
            end
            wr_data    = {ns, no};
            res_size_d = 32'(ns);
            res_addr_d = (cmd_q == CMD_SHRINK_DOWN) ? 32'(no + AW'(ns)) : 32'(no);
          end
          default: begin
          end
        endcase
      end

      S_JB: begin
        da_d    = rdata;
        rd_en   = 1'b1;
        rd_idx  = IW'(b_q);
        state_d = S_JMOD;
      end

      S_JMOD: begin
        // merged area keeps the start of slot_a in either order
        lo         = (a_q < b_q) ? IW'(a_q) : IW'(b_q);
        hi         = (a_q < b_q) ? IW'(b_q) : IW'(a_q);
        ns         = sa + rd_s;
        wr_en      = 1'b1;
        wr_idx     = lo;
        wr_data    = {ns, da_q[AW-1:0]};
        best_d     = hi;
        res_slot_d = 8'(lo);
        res_size_d = 32'(ns);
        res_addr_d = 32'(da_q[AW-1:0]);
        state_d    = S_JCLR;
      end

      S_JCLR: begin
        wr_en   = 1'b1;
        wr_idx  = best_q;
        state_d = S_RESP;
        if (CW'(best_q) == CW'(top_q - 1'b1)) begin
          top_d   = top_q - 1'b1;
          state_d = S_TRIM_RD;
        end else if (gap_q < TW'(SLOTS)) begin
          gap_d = gap_q + 1'b1;
        end
      end

      S_TRIM_RD: begin
        if (top_q != '0 && gap_q != '0) begin
          rd_en   = 1'b1;
          rd_idx  = IW'(top_q - 1'b1);
          state_d = S_TRIM_CHK;
        end else begin
          state_d = S_RESP;
        end
      end

      S_TRIM_CHK: begin
        if (rd_s == '0) begin
          gap_d   = gap_q - 1'b1;
          top_d   = top_q - 1'b1;
          state_d = S_TRIM_RD;
        end else begin
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      cmd_q      <= '0;
      a_q        <= '0;
      b_q        <= '0;
      addr_q     <= '0;
      amt_q      <= '0;
      top_q      <= '0;
      gap_q      <= '0;
      idx_q      <= '0;
      fsum_q     <= '0;
      hint_q     <= '0;
      large_q    <= '0;
      bsize_q    <= '0;
      chk_q      <= '0;
      best_q     <= '0;
      pend_q     <= 1'b0;
      have_q     <= 1'b0;
      baddr_q    <= '0;
      da_q       <= '0;
      res_slot_q <= '0;
      res_size_q <= '0;
      res_addr_q <= '0;
      res_st_q   <= ST_OK;
    end else begin
      state_q    <= state_d;
      cmd_q      <= cmd_d;
      a_q        <= a_d;
      b_q        <= b_d;
      addr_q     <= addr_d;
      amt_q      <= amt_d;
      top_q      <= top_d;
      gap_q      <= gap_d;
      idx_q      <= idx_d;
      fsum_q     <= fsum_d;
      hint_q     <= hint_d;
      large_q    <= large_d;
      bsize_q    <= bsize_d;
      chk_q      <= chk_d;
      best_q     <= best_d;
      pend_q     <= pend_d;
      have_q     <= have_d;
      baddr_q    <= baddr_d;
      da_q       <= da_d;
      res_slot_q <= res_slot_d;
      res_size_q <= res_size_d;
      res_addr_q <= res_addr_d;
      res_st_q   <= res_st_d;
    end
  end

  assign busy         = state_q != S_IDLE;
  assign done_o       = state_q == S_RESP;
  assign slot_o       = res_slot_q;
  assign size_o       = res_size_q;
  assign addr_out_o   = res_addr_q;
  assign status_o     = res_st_q;
  assign free_total_o = fsum_q;

  `BFA_ASSERT_CLK(a_accept_busy, start && !busy |=> busy, "accepted command did not raise busy")
  `BFA_ASSERT_CLK(a_done_next_idle, done_o |=> !busy, "no return to idle after result")
  `BFA_ASSERT_NEVER(a_top_range, top_q > TW'(SLOTS), "region top beyond table")
  `BFA_ASSERT_NEVER(a_wr_idle, wr_en && state_q == S_IDLE, "memory write while idle")

endmodule

`default_nettype wire

[design/bfa_mem.sv]
// ----------------------------------------------------------------------------
// bfa_mem
// single port write, single port read memory, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_idx_i,
  output logic      [WIDTH-1:0]         rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_idx_i,
  input  wire logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_idx_i];
    end
  end

endmodule

`default_nettype wire
